// ===== rtl/slp_pkg.sv =====
package slp_pkg;

  localparam int COORD_BITS    = 12;
  localparam int PHASE_BITS    = 12;
  localparam int MAX_PATTERNS  = 16;

  localparam int WIDTH_BITS    = 12;
  localparam int SIZE_BITS     = 13;
  localparam int COUNT_BITS    = 5;
  localparam int INDEX_BITS    = 4;
  localparam int CMD_BITS      = 2;

  localparam int DIV_BITS      = COORD_BITS + PHASE_BITS;
  localparam int QTR           = 1 << (PHASE_BITS - 2);
  localparam int ROM_ADDR_BITS = PHASE_BITS - 1;
  localparam int CODE_BITS_W   = $clog2(SIZE_BITS + 1);
  localparam int GRAY_W        = 1 << CODE_BITS_W;
  localparam int LIMIT_W       = 7;
  localparam int COS_BITS      = 31;
  localparam int Q30           = 30;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  localparam logic [WIDTH_BITS-1:0] VSW_RESET   = 12'd16;
  localparam logic [WIDTH_BITS-1:0] HSW_RESET   = 12'd16;
  localparam logic [SIZE_BITS-1:0]  IMG_W_RESET = 13'd1024;
  localparam logic [SIZE_BITS-1:0]  IMG_H_RESET = 13'd768;
  localparam logic [COUNT_BITS-1:0] FC_RESET    = 5'd4;

  typedef enum logic [2:0] {
    REG_VSW   = 3'd0,
    REG_HSW   = 3'd1,
    REG_IMG_W = 3'd2,
    REG_IMG_H = 3'd3,
    REG_FC    = 3'd4
  } reg_idx_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_FRINGE = 2'd0,
    CMD_GRAY   = 2'd1,
    CMD_INV    = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ERR    = 2'd0,
    OP_FRINGE = 2'd1,
    OP_GRAY   = 2'd2,
    OP_INV    = 2'd3
  } op_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] vsw;
    logic [WIDTH_BITS-1:0] hsw;
    logic [SIZE_BITS-1:0]  img_w;
    logic [SIZE_BITS-1:0]  img_h;
    logic [COUNT_BITS-1:0] fringe_count;
  } cfg_t;

  typedef struct packed {
    op_t                    op;
    logic [INDEX_BITS-1:0]  k;
    logic [CODE_BITS_W-1:0] shift;
    logic [COORD_BITS-1:0]  coord;
    logic [WIDTH_BITS-1:0]  width;
  } work_t;

  typedef logic [COS_BITS-1:0] cos_rom_t [QTR+1];

  localparam longint HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave cosine, Q30, Taylor series to x^16
  function automatic cos_rom_t cos_table();
    cos_rom_t    t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int u = 0; u <= QTR; u++) begin
      if (u == 0) begin
        t[u] = COS_BITS'(64'd1 << Q30);
      end else if (u >= QTR) begin
        t[u] = '0;
      end else begin
        x    = (HALF_PI_Q30 * 64'(u)) >> (PHASE_BITS - 2);
        x2   = (x * x) >> Q30;
        term = 64'd1 << Q30;
        sum  = longint'(term);
        for (int i = 1; i <= 8; i++) begin
          term = ((term * x2) >> Q30) / 64'((2 * i - 1) * (2 * i));
          if ((i % 2) == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << Q30)) sum = longint'(1) << Q30;
        t[u] = COS_BITS'(sum);
      end
    end
    return t;
  endfunction

endpackage

// ===== rtl/slp_if.sv =====
interface slp_in_if;
  logic                         valid;
  logic                         ready;
  logic [slp_pkg::CMD_BITS-1:0]   command;
  logic                         orientation;
  logic [slp_pkg::INDEX_BITS-1:0] pattern_index;
  logic [slp_pkg::COORD_BITS-1:0] pixel_row;
  logic [slp_pkg::COORD_BITS-1:0] pixel_col;
  modport source(output valid, command, orientation, pattern_index, pixel_row, pixel_col,
                 input ready);
  modport sink(input valid, command, orientation, pattern_index, pixel_row, pixel_col,
               output ready);
endinterface

interface slp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] intensity;
  logic       index_error;
  modport source(output valid, intensity, index_error, input ready);
  modport sink(input valid, intensity, index_error, output ready);
endinterface

// ===== rtl/slp_front.sv =====
module slp_front (
  input  logic           clk,
  input  logic           rst,
  input  slp_pkg::cfg_t  cfg,
  slp_in_if.sink         pix_in,
  output logic           f_valid,
  output slp_pkg::work_t f_work,
  input  logic           f_take
);
  import slp_pkg::*;

  localparam int SZ_EXT = WIDTH_BITS + SIZE_BITS + 1;

  logic [COORD_BITS-1:0]  coord;
  logic [WIDTH_BITS-1:0]  width;
  logic [SIZE_BITS-1:0]   size;
  logic [CODE_BITS_W-1:0] bits;
  logic [LIMIT_W-1:0]     lim_f;
  logic [LIMIT_W-1:0]     lim_g;
  logic                   err_f;
  logic                   err_g;
  work_t                  work_next;

  assign pix_in.ready = !f_valid || f_take;

  always_comb begin
    coord = pix_in.orientation ? pix_in.pixel_row : pix_in.pixel_col;
    width = pix_in.orientation ? cfg.hsw : cfg.vsw;
    size  = pix_in.orientation ? cfg.img_h : cfg.img_w;
    if (width == '0) width = WIDTH_BITS'(1);
    // code bits: smallest n with width * 2^n >= size
    bits = CODE_BITS_W'(SIZE_BITS);
    for (int n = SIZE_BITS; n >= 0; n--) begin
      if ((SZ_EXT'(width) << n) >= SZ_EXT'(size)) bits = CODE_BITS_W'(n);
    end
    lim_f = (LIMIT_W'(cfg.fringe_count) < LIMIT_W'(MAX_PATTERNS)) ?
            LIMIT_W'(cfg.fringe_count) : LIMIT_W'(MAX_PATTERNS);
    lim_g = (LIMIT_W'(bits) < LIMIT_W'(MAX_PATTERNS)) ?
            LIMIT_W'(bits) : LIMIT_W'(MAX_PATTERNS);
    err_f = LIMIT_W'(pix_in.pattern_index) >= lim_f;
    err_g = LIMIT_W'(pix_in.pattern_index) >= lim_g;
    work_next.k     = pix_in.pattern_index;
    work_next.shift = CODE_BITS_W'(bits - CODE_BITS_W'(1) - CODE_BITS_W'(pix_in.pattern_index));
    work_next.coord = coord;
    work_next.width = width;
    unique case (cmd_t'(pix_in.command))
      CMD_FRINGE: work_next.op = err_f ? OP_ERR : OP_FRINGE;
      CMD_GRAY:   work_next.op = err_g ? OP_ERR : OP_GRAY;
      CMD_INV:    work_next.op = err_g ? OP_ERR : OP_INV;
      default:    work_next.op = OP_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (pix_in.ready) begin
      f_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.ready && pix_in.valid) f_work <= work_next;
  end

endmodule

// ===== rtl/slp_queue.sv =====
module slp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_take,
  input  slp_pkg::work_t push_work,
  output logic           pop_valid,
  input  logic           pop_take,
  output slp_pkg::work_t pop_work
);
  import slp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_take = count != (PTR_W+1)'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_work  = mem[rp];
  assign do_push   = push_valid && push_take;
  assign do_pop    = pop_valid && pop_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + PTR_W'(1);
      if (do_pop) rp <= rp + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_work;
  end

endmodule

// ===== rtl/slp_back.sv =====
module slp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  slp_pkg::work_t q_work,
  slp_out_if.source      pix_out
);
  import slp_pkg::*;

  localparam cos_rom_t COS_ROM = cos_table();

  typedef struct packed {
    work_t                 w;
    logic [WIDTH_BITS-1:0] rem;
    logic [DIV_BITS-1:0]   num;
    logic [DIV_BITS-1:0]   quo;
  } div_t;

  div_t dstg      [DIV_BITS];
  div_t dstg_next [DIV_BITS];
  logic dvld      [DIV_BITS];
  logic en;

  logic [PHASE_BITS-1:0]    phase;
  logic [1:0]               quad;
  logic [PHASE_BITS-3:0]    r;
  logic [ROM_ADDR_BITS-1:0] addr;
  logic [COORD_BITS-1:0]    idx;
  logic [GRAY_W-1:0]        gray;
  logic [7:0]               flat_next;

  logic                     rv;
  op_t                      rop;
  logic                     rneg;
  logic [7:0]               rflat;
  logic [COS_BITS-1:0]      rcos;

  logic signed [38:0]       vneg;
  logic [8:0]               vpos;
  logic [7:0]               level;

  assign en     = !pix_out.valid || pix_out.ready;
  assign q_take = en;

  always_comb begin
    div_t                  prev;
    logic [WIDTH_BITS:0]   t;
    logic                  ge;
    for (int s = 0; s < DIV_BITS; s++) begin
      if (s == 0) begin
        prev.w   = q_work;
        prev.rem = '0;
        prev.num = {q_work.coord, PHASE_BITS'(0)};
        prev.quo = '0;
      end else begin
        prev = dstg[s-1];
      end
      t  = {prev.rem, prev.num[DIV_BITS-1]};
      ge = t >= {1'b0, prev.w.width};
      dstg_next[s].w   = prev.w;
      dstg_next[s].rem = ge ? WIDTH_BITS'(t - {1'b0, prev.w.width}) : t[WIDTH_BITS-1:0];
      dstg_next[s].num = {prev.num[DIV_BITS-2:0], 1'b0};
      dstg_next[s].quo = {prev.quo[DIV_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_BITS; s++) dvld[s] <= 1'b0;
    end else if (en) begin
      dvld[0] <= q_valid;
      for (int s = 1; s < DIV_BITS; s++) dvld[s] <= dvld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_BITS; s++) dstg[s] <= dstg_next[s];
    end
  end

  // phase, quadrant and stripe bit
  always_comb begin
    div_t d;
    d     = dstg[DIV_BITS-1];
    phase = PHASE_BITS'(d.quo[PHASE_BITS-1:0]
            + (PHASE_BITS'({1'b0, d.w.k} + 5'd1) << (PHASE_BITS - 2)));
    quad  = phase[PHASE_BITS-1:PHASE_BITS-2];
    r     = phase[PHASE_BITS-3:0];
    addr  = quad[0] ? ROM_ADDR_BITS'(ROM_ADDR_BITS'(QTR) - {1'b0, r}) : {1'b0, r};
    idx   = d.quo[DIV_BITS-1:PHASE_BITS];
    gray  = GRAY_W'(idx ^ (idx >> 1));
    case (d.w.op)
      OP_GRAY: flat_next = gray[d.w.shift] ? 8'hFF : 8'h00;
      OP_INV:  flat_next = gray[d.w.shift] ? 8'h00 : 8'hFF;
      default: flat_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= dvld[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rop   <= dstg[DIV_BITS-1].w.op;
      rneg  <= quad[1] ^ quad[0];
      rflat <= flat_next;
      rcos  <= COS_ROM[addr];
    end
  end

  always_comb begin
    vneg = (39'sd127 <<< Q30) - signed'({1'b0, rcos, 7'd0});
    vpos = 9'd127 + 9'(rcos[COS_BITS-1:23]);
    if (rneg) level = (vneg <= 0) ? 8'd0 : vneg[37:30];
    else level = vpos[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en) begin
      pix_out.valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.intensity   <= (rop == OP_FRINGE) ? level : rflat;
      pix_out.index_error <= rop == OP_ERR;
    end
  end

endmodule

// ===== rtl/structured_light_pattern_pixel_unit.sv =====
// Words pass the classify register, queue, fully pipelined 24-step phase divider,
// ROM register and output register; one word per cycle unless pix_out stalls.
// A 4-word queue decouples the classify stage from the divider/ROM pipeline.
// Reset (rst, synchronous, active high) empties the pipeline and queue and
// restores the register reset values.
module structured_light_pattern_pixel_unit (
  input  logic                              clk,
  input  logic                              rst,
  slp_in_if.sink                            pix_in,
  slp_out_if.source                         pix_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [slp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [slp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import slp_pkg::*;

  cfg_t     cfg;
  reg_idx_t ridx;
  logic     f_valid;
  logic     f_take;
  work_t    f_work;
  logic     q_valid;
  logic     q_take;
  work_t    q_work;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vsw          <= VSW_RESET;
      cfg.hsw          <= HSW_RESET;
      cfg.img_w        <= IMG_W_RESET;
      cfg.img_h        <= IMG_H_RESET;
      cfg.fringe_count <= FC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_VSW:   cfg.vsw          <= pwdata[WIDTH_BITS-1:0];
        REG_HSW:   cfg.hsw          <= pwdata[WIDTH_BITS-1:0];
        REG_IMG_W: cfg.img_w        <= pwdata[SIZE_BITS-1:0];
        REG_IMG_H: cfg.img_h        <= pwdata[SIZE_BITS-1:0];
        REG_FC:    cfg.fringe_count <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_VSW:   prdata = APB_DATA_BITS'(cfg.vsw);
      REG_HSW:   prdata = APB_DATA_BITS'(cfg.hsw);
      REG_IMG_W: prdata = APB_DATA_BITS'(cfg.img_w);
      REG_IMG_H: prdata = APB_DATA_BITS'(cfg.img_h);
      REG_FC:    prdata = APB_DATA_BITS'(cfg.fringe_count);
      default:   prdata = '0;
    endcase
  end

  slp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix_in  (pix_in),
    .f_valid (f_valid),
    .f_work  (f_work),
    .f_take  (f_take)
  );

  slp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_take  (f_take),
    .push_work  (f_work),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_work   (q_work)
  );

  slp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_work  (q_work),
    .pix_out (pix_out)
  );

endmodule

// ===== rtl/slp_checker.sv =====
module slp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] intensity,
  input logic       index_error,
  input logic       pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(intensity) && $stable(index_error))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> intensity == 8'd0)
    else $error("index error with nonzero intensity");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind structured_light_pattern_pixel_unit slp_checker u_slp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .intensity   (pix_out.intensity),
  .index_error (pix_out.index_error),
  .pready      (pready)
);

// ===== tb/sv/tb_structured_light_pattern_pixel_unit.sv =====
module tb_structured_light_pattern_pixel_unit;
  import slp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  slp_in_if pix_in ();
  slp_out_if pix_out ();

  structured_light_pattern_pixel_unit dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [7:0] intensity;
    logic       index_error;
  } level_t;

  typedef struct {
    cmd_t        cmd;
    logic        horiz;
    logic [3:0]  k;
    logic [11:0] row;
    logic [11:0] col;
    bit          known;
    level_t      lvl;
  } pix_row_t;

  logic [11:0] vsw_m, hsw_m;
  logic [12:0] imgw_m, imgh_m;
  logic [4:0]  fc_m;

  level_t levels_due[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int quiet = 0;
  logic [30:0] cos_q30 [0:QTR];

  initial begin
    for (int u = 0; u <= QTR; u++) begin
      logic [63:0] x, x2, term;
      longint s;
      if (u == 0) cos_q30[u] = 31'(64'd1 << 30);
      else if (u >= QTR) cos_q30[u] = '0;
      else begin
        x = (64'd1686629713 * 64'(u)) / 64'(QTR);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        s = longint'(term);
        for (int i = 1; i <= 8; i++) begin
          term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
          if (i % 2 == 1) s -= longint'(term);
          else s += longint'(term);
        end
        if (s < 0) s = 0;
        if (s > (longint'(1) << 30)) s = longint'(1) << 30;
        cos_q30[u] = 31'(s);
      end
    end
  end

  function automatic logic [7:0] fringe_gray(logic [11:0] coord, logic [11:0] w,
                                             logic [3:0] k);
    logic [63:0] p, r;
    logic [1:0] quad;
    logic [30:0] c;
    longint v;
    p = (64'(coord) << PHASE_BITS) / 64'(w);
    p = (p + (64'(k) + 1) * QTR) & ((64'd1 << PHASE_BITS) - 1);
    quad = p[PHASE_BITS-1 -: 2];
    r = p & (QTR - 1);
    c = (quad == 0 || quad == 2) ? cos_q30[r] : cos_q30[QTR - r];
    v = longint'(127) << 30;
    if (quad == 1 || quad == 2) v -= longint'(c) * 128;
    else v += longint'(c) * 128;
    if (v <= 0) return 8'd0;
    v = v >>> 30;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic level_t pattern_level(cmd_t cmd, logic horiz, logic [3:0] k,
                                           logic [11:0] row, logic [11:0] col);
    level_t o;
    logic [11:0] coord, w;
    int unsigned sz, codes, nb, m, idx, g, lim;
    o = '0;
    coord = horiz ? row : col;
    w = horiz ? hsw_m : vsw_m;
    sz = horiz ? imgh_m : imgw_m;
    if (w == 0) w = 1;
    if (cmd == CMD_FRINGE) begin
      lim = fc_m < MAX_PATTERNS ? fc_m : MAX_PATTERNS;
      if (k >= lim) o.index_error = 1'b1;
      else o.intensity = fringe_gray(coord, w, k);
    end else if (cmd == CMD_GRAY || cmd == CMD_INV) begin
      codes = (sz + w - 1) / w;
      nb = 0;
      if (codes >= 2) begin
        m = codes - 1;
        while (m != 0) begin
          nb++;
          m >>= 1;
        end
      end
      lim = nb < MAX_PATTERNS ? nb : MAX_PATTERNS;
      if (k >= lim) o.index_error = 1'b1;
      else begin
        idx = coord / w;
        g = idx ^ (idx >> 1);
        o.intensity = ((g >> (nb - 1 - k)) & 1) ? 8'd255 : 8'd0;
        if (cmd == CMD_INV) o.intensity = ~o.intensity;
      end
    end else begin
      o.index_error = 1'b1;
    end
    return o;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_VSW: vsw_m = val[11:0];
      REG_HSW: hsw_m = val[11:0];
      REG_IMG_W: imgw_m = val[12:0];
      REG_IMG_H: imgh_m = val[12:0];
      default: fc_m = val[4:0];
    endcase
  endtask

  task automatic set_regs(logic [11:0] vw, logic [11:0] hw, logic [12:0] iw,
                          logic [12:0] ih, logic [4:0] fc);
    wait (levels_due.size() == 0);
    repeat (40) @(posedge clk);
    reg_write(REG_VSW, 32'(vw));
    reg_write(REG_HSW, 32'(hw));
    reg_write(REG_IMG_W, 32'(iw));
    reg_write(REG_IMG_H, 32'(ih));
    reg_write(REG_FC, 32'(fc));
  endtask

  task automatic send_word(pix_row_t t);
    level_t due;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.command <= t.cmd;
    pix_in.orientation <= t.horiz;
    pix_in.pattern_index <= t.k;
    pix_in.pixel_row <= t.row;
    pix_in.pixel_col <= t.col;
    do @(posedge clk); while (!pix_in.ready);
    if (t.known) due = t.lvl;
    else due = pattern_level(t.cmd, t.horiz, t.k, t.row, t.col);
    levels_due.insert(levels_due.size(), due);
  endtask

  function automatic pix_row_t random_word();
    pix_row_t t;
    t.cmd = cmd_t'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
    t.horiz = 1'($urandom_range(1));
    t.k = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(5));
    t.row = 12'($urandom_range(4095));
    t.col = 12'($urandom_range(4095));
    t.known = 0;
    t.lvl = '0;
    return t;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
    pix_in.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) pix_out.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      pix_out.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else pix_out.ready <= !($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (levels_due.size() == 0) begin
        $error("unexpected word: intensity %0d index_error %0b",
               pix_out.intensity, pix_out.index_error);
        errors++;
      end else begin
        level_t e;
        e = levels_due.pop_front();
        if (pix_out.intensity !== e.intensity) begin
          $error("intensity: expected %0d, got %0d", e.intensity, pix_out.intensity);
          errors++;
        end
        if (pix_out.index_error !== e.index_error) begin
          $error("index_error: expected %0b, got %0b", e.index_error, pix_out.index_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || psel)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  pix_row_t dir_rows[$];

  function automatic pix_row_t mk(cmd_t c, logic h, logic [3:0] k, logic [11:0] r,
                                  logic [11:0] cl, bit kn, logic [7:0] lv, logic er);
    pix_row_t t;
    t.cmd = c; t.horiz = h; t.k = k; t.row = r; t.col = cl;
    t.known = kn; t.lvl = '{intensity: lv, index_error: er};
    return t;
  endfunction

  initial begin
    pix_in.valid = 1'b0;
    pix_in.command = '0;
    pix_in.orientation = 1'b0;
    pix_in.pattern_index = '0;
    pix_in.pixel_row = '0;
    pix_in.pixel_col = '0;
    vsw_m = VSW_RESET; hsw_m = HSW_RESET; imgw_m = IMG_W_RESET;
    imgh_m = IMG_H_RESET; fc_m = FC_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      mk(CMD_FRINGE, 0, 0, 0, 0, 1, 8'd127, 0),
      mk(CMD_FRINGE, 0, 1, 0, 0, 1, 8'd0, 0),
      mk(CMD_FRINGE, 0, 2, 0, 0, 1, 8'd127, 0),
      mk(CMD_FRINGE, 0, 3, 0, 0, 1, 8'd255, 0),
      mk(CMD_FRINGE, 0, 4, 0, 0, 1, 8'd0, 1),
      mk(CMD_FRINGE, 1, 15, 4095, 4095, 1, 8'd0, 1),
      mk(CMD_RSVD, 0, 0, 0, 0, 1, 8'd0, 1),
      mk(CMD_RSVD, 1, 15, 4095, 4095, 1, 8'd0, 1),
      mk(CMD_GRAY, 0, 0, 0, 0, 1, 8'd0, 0),
      mk(CMD_INV, 0, 0, 0, 0, 1, 8'd255, 0),
      mk(CMD_GRAY, 0, 6, 0, 0, 1, 8'd0, 1),
      mk(CMD_GRAY, 1, 6, 0, 0, 1, 8'd0, 1),
      mk(CMD_GRAY, 0, 0, 0, 4095, 0, 0, 0),
      mk(CMD_INV, 1, 5, 4095, 0, 0, 0, 0),
      mk(CMD_FRINGE, 0, 2, 0, 4095, 0, 0, 0),
      mk(CMD_FRINGE, 1, 1, 2741, 0, 0, 0, 0),
      mk(CMD_GRAY, 0, 5, 0, 1023, 0, 0, 0),
      mk(CMD_INV, 1, 3, 767, 0, 0, 0, 0)
    };
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    pix_in.valid <= 1'b0;

    set_regs(12'd0, 12'd4095, 13'd4096, 13'd4096, 5'd16);
    foreach (dir_rows[i]) begin
      dir_rows[i].known = 0;
      send_word(dir_rows[i]);
    end
    pix_in.valid <= 1'b0;
    run_random(150);

    set_regs(12'd1, 12'd1, 13'd1, 13'd8191, 5'd0);
    run_random(100);

    set_regs(12'd7, 12'd33, 13'd4096, 13'd1, 5'd31);
    send_idle_pct = 61;
    run_random(200);

    set_regs(12'd16, 12'd3, 13'd1000, 13'd640, 5'd3);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    run_random(200);

    set_regs(12'd4095, 12'd250, 13'd8191, 13'd2048, 5'd12);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_random(200);

    set_regs(12'd2, 12'd64, 13'd1920, 13'd1080, 5'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait (pix_out.ready);
    hold_cycles <= 300;
    run_random(200);

    wait (levels_due.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/slp_pkg.sv
rtl/slp_if.sv
rtl/slp_front.sv
rtl/slp_queue.sv
rtl/slp_back.sv
rtl/structured_light_pattern_pixel_unit.sv
rtl/slp_checker.sv
tb/sv/tb_structured_light_pattern_pixel_unit.sv
